@@ rtl/core/point_store_support_search_top_macros.svh @@
// ----------------------------------------------------------------------------
// Point store support search: assertion macros
// Shared concurrent assertion forms. Each one is clocked on clk and is
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POINT_STORE_SUPPORT_SEARCH_TOP_MACROS_SVH
`define POINT_STORE_SUPPORT_SEARCH_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PSSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define PSSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/psss_pkg.sv @@
// ----------------------------------------------------------------------------
// Point store support search: package
// Transaction types, request and status codes, and fixed widths.
// ----------------------------------------------------------------------------
package psss_pkg;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 10;
  // Exact sum of three 32x32 signed products fits in 65 signed bits.
  localparam int DOT_W   = 65;

  typedef enum logic [1:0] {
    ACT_FIND        = 2'd0,
    ACT_FIND_OR_ADD = 2'd1,
    ACT_FURTHEST    = 2'd2,
    ACT_CLEAR       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_ADDED     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [INDEX_W-1:0]        index_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    action_t action;
    coord_t  coord_x;
    coord_t  coord_y;
    coord_t  coord_z;
  } req_t;

  typedef struct packed {
    status_t status;
    index_t  slot;
    coord_t  result_x;
    coord_t  result_y;
    coord_t  result_z;
  } rsp_t;

endpackage

@@ rtl/core/psss_point_mem.sv @@
// ----------------------------------------------------------------------------
// Point store support search: point memory
// Single-port-write, single-port-read store of 96-bit points with a
// registered read port.
// ----------------------------------------------------------------------------
module psss_point_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  psss_pkg::point_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output psss_pkg::point_t rdata
);

  psss_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/psss_dot_pipe.sv @@
// ----------------------------------------------------------------------------
// Point store support search: dot product pipeline
// Two stages: three parallel 32x32 signed products, then their exact sum.
// The point and its index travel alongside the arithmetic.
// ----------------------------------------------------------------------------
module psss_dot_pipe #(
  parameter int IDX_W = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [IDX_W-1:0]                   in_idx,
  input  psss_pkg::point_t                   in_pt,
  input  psss_pkg::point_t                   dir,
  output logic                               out_valid,
  output logic [IDX_W-1:0]                   out_idx,
  output psss_pkg::point_t                   out_pt,
  output logic signed [psss_pkg::DOT_W-1:0]  out_dot,
  output logic                               busy
);

  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_idx;
  psss_pkg::point_t     s1_pt;
  logic signed [63:0]   prod_x;
  logic signed [63:0]   prod_y;
  logic signed [63:0]   prod_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= in_idx;
    s1_pt   <= in_pt;
    prod_x  <= 64'(in_pt.x) * 64'(dir.x);
    prod_y  <= 64'(in_pt.y) * 64'(dir.y);
    prod_z  <= 64'(in_pt.z) * 64'(dir.z);
    out_idx <= s1_idx;
    out_pt  <= s1_pt;
    out_dot <= psss_pkg::DOT_W'(prod_x) + psss_pkg::DOT_W'(prod_y)
             + psss_pkg::DOT_W'(prod_z);
  end

  assign busy = s1_valid | out_valid;

endmodule

@@ rtl/core/point_store_support_search_top.sv @@
// ----------------------------------------------------------------------------
// Point store support search: top level
// Keeps a store of 3D Q16.16 points in a synchronous memory and serves
// exact-match lookup, find-or-add, support-point search and clear requests.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                        | Carries
//   --------+--------------------------------+-----------------------------
//   request | req_valid, req_ready, req      | action and three coordinates
//   result  | rsp_valid, rsp_ready, rsp      | status, index, three coords
//
// A find or find-or-add reads one entry per cycle and stops at the first
// match; a furthest search reads every entry through the two-stage dot
// product; clear and a furthest on an empty store go straight to FINISH.
// Reset is synchronous and empties the store through the point count. A
// stalled result holds the block in FINISH with req_ready low.
module point_store_support_search_top #(
  parameter int STORE_SIZE = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  psss_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output psss_pkg::rsp_t rsp
);

`include "point_store_support_search_top_macros.svh"

  localparam int IDX_W = $clog2(STORE_SIZE);
  localparam int CNT_W = $clog2(STORE_SIZE + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t                            state;
  psss_pkg::req_t                    cur;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  issue_addr;
  logic                              rd_valid;
  logic [IDX_W-1:0]                  rd_idx;
  psss_pkg::point_t                  rd_data;
  logic                              found;
  logic [IDX_W-1:0]                  found_idx;
  logic                              best_valid;
  logic signed [psss_pkg::DOT_W-1:0] best_dot;
  logic [IDX_W-1:0]                  best_idx;
  psss_pkg::point_t                  best_pt;
  psss_pkg::rsp_t                    pend;

  psss_pkg::point_t                  cur_pt;
  logic                              is_match;
  logic                              hit;
  logic                              rd_en;
  logic                              scan_done;
  logic                              can_add;
  logic                              mem_we;
  logic                              rsp_load;
  psss_pkg::rsp_t                    res_scan;

  logic                              dot_in_valid;
  logic                              dot_valid;
  logic [IDX_W-1:0]                  dot_idx;
  psss_pkg::point_t                  dot_pt;
  logic signed [psss_pkg::DOT_W-1:0] dot_val;
  logic                              dot_busy;

  assign cur_pt   = '{x: cur.coord_x, y: cur.coord_y, z: cur.coord_z};
  assign is_match = (cur.action == psss_pkg::ACT_FIND)
                 || (cur.action == psss_pkg::ACT_FIND_OR_ADD);
  assign req_ready = (state == IDLE);

  // The first matching entry in index order wins; once it is seen no
  // further reads are issued and any read still in flight is ignored.
  assign hit   = rd_valid && is_match && !found && (rd_data == cur_pt);
  assign rd_en = (state == SCAN) && (issue_addr < count) && !found && !hit;

  // The scan is over once nothing is issued and both the memory read stage
  // and the dot product pipeline are empty.
  assign scan_done = (state == SCAN) && !rd_en && !rd_valid && !dot_busy;
  assign can_add   = (count < CNT_W'(STORE_SIZE));
  assign mem_we    = scan_done && (cur.action == psss_pkg::ACT_FIND_OR_ADD)
                  && !found && can_add;

  // The finished result moves to the output register once it is free.
  assign rsp_load = (state == FINISH) && (!rsp_valid || rsp_ready);

  assign dot_in_valid = rd_valid && (cur.action == psss_pkg::ACT_FURTHEST);

  always_comb begin
    res_scan = '0;
    unique case (cur.action)
      psss_pkg::ACT_FIND: begin
        if (found) begin
          res_scan.slot = psss_pkg::index_t'(found_idx);
        end else begin
          res_scan.status = psss_pkg::ST_NOT_FOUND;
        end
      end
      psss_pkg::ACT_FIND_OR_ADD: begin
        if (found) begin
          res_scan.slot = psss_pkg::index_t'(found_idx);
        end else if (can_add) begin
          res_scan.status = psss_pkg::ST_ADDED;
          res_scan.slot   = psss_pkg::index_t'(count);
        end else begin
          res_scan.status = psss_pkg::ST_FULL;
        end
      end
      psss_pkg::ACT_FURTHEST: begin
        res_scan.slot     = psss_pkg::index_t'(best_idx);
        res_scan.result_x = best_pt.x;
        res_scan.result_y = best_pt.y;
        res_scan.result_z = best_pt.z;
      end
      psss_pkg::ACT_CLEAR: begin
        res_scan.status = psss_pkg::ST_DONE;
      end
    endcase
  end

  psss_point_mem #(
    .DEPTH (STORE_SIZE),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (cur_pt),
    .re    (rd_en),
    .raddr (issue_addr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  psss_dot_pipe #(
    .IDX_W (IDX_W)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_in_valid),
    .in_idx    (rd_idx),
    .in_pt     (rd_data),
    .dir       (cur_pt),
    .out_valid (dot_valid),
    .out_idx   (dot_idx),
    .out_pt    (dot_pt),
    .out_dot   (dot_val),
    .busy      (dot_busy)
  );

  // Scan payload: read tag and the running best of a furthest search.
  // Only a strictly greater dot product replaces the best, so ties keep
  // the lowest index.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx     <= issue_addr[IDX_W-1:0];
      issue_addr <= issue_addr + CNT_W'(1);
    end
    if (hit) begin
      found_idx <= rd_idx;
    end
    if (dot_valid && (!best_valid || (dot_val > best_dot))) begin
      best_dot <= dot_val;
      best_idx <= dot_idx;
      best_pt  <= dot_pt;
    end
    if (req_valid && req_ready) begin
      cur        <= req;
      issue_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      best_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (hit) begin
        found <= 1'b1;
      end
      if (dot_valid) begin
        best_valid <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            found      <= 1'b0;
            best_valid <= 1'b0;
            priority if (req.action == psss_pkg::ACT_CLEAR) begin
              count <= '0;
              pend  <= '0;
              state <= FINISH;
            end else if ((req.action == psss_pkg::ACT_FURTHEST) && (count == '0)) begin
              pend  <= '{status: psss_pkg::ST_EMPTY, default: '0};
              state <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan_done) begin
            pend  <= res_scan;
            state <= FINISH;
            if (mem_we) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        FINISH: begin
          if (rsp_load) begin
            rsp   <= pend;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `PSSS_ASSERT(a_count_bound, count <= CNT_W'(STORE_SIZE), "point count above store depth")
  `PSSS_ASSERT_NEXT(a_append_count, mem_we, count == $past(count) + CNT_W'(1), "append lost count")
  `PSSS_ASSERT(a_finish_drained, (state != FINISH) || (!rd_valid && !dot_busy), "result before drain")
  `PSSS_ASSERT(a_stop_after_hit, !found || !rd_en, "read issued after a match")
  `PSSS_ASSERT_NEXT(a_best_rises, dot_valid && best_valid, best_dot >= $past(best_dot), "best fell")

endmodule

@@ bench/psss_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// Point store support search: scoreboard
// Holds a private copy of the point store, works out the result of every
// accepted request and compares results from the block against it in order.
// ----------------------------------------------------------------------------
package psss_tb_pkg;

  import psss_pkg::*;

  localparam int STORE_DEPTH = 1024;

  class point_store_scoreboard;

    coord_t      store_x [STORE_DEPTH];
    coord_t      store_y [STORE_DEPTH];
    coord_t      store_z [STORE_DEPTH];
    int unsigned stored;
    rsp_t        expected_q [$];
    int unsigned error_count;

    function new();
      stored = 0;
      error_count = 0;
    endfunction

    // Lowest index whose three coordinates equal the request exactly.
    function bit lookup(coord_t x, coord_t y, coord_t z, output int unsigned idx);
      idx = 0;
      for (int unsigned i = 0; i < stored; i++) begin
        if (store_x[i] == x && store_y[i] == y && store_z[i] == z) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Exact dot product; the sum of three 32x32 products needs 65 bits, 67 leaves margin.
    function logic signed [66:0] dot(int unsigned i, req_t r);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] pz;
      px = 64'(store_x[i]) * 64'(r.coord_x);
      py = 64'(store_y[i]) * 64'(r.coord_y);
      pz = 64'(store_z[i]) * 64'(r.coord_z);
      return 67'(px) + 67'(py) + 67'(pz);
    endfunction

    function rsp_t predict(req_t r);
      rsp_t               res;
      int unsigned        idx;
      int unsigned        best;
      logic signed [66:0] best_dot;
      logic signed [66:0] cur;
      res = '0;
      res.status = ST_DONE;
      case (r.action)
        ACT_FIND: begin
          if (lookup(r.coord_x, r.coord_y, r.coord_z, idx)) begin
            res.slot = index_t'(idx);
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        ACT_FIND_OR_ADD: begin
          if (lookup(r.coord_x, r.coord_y, r.coord_z, idx)) begin
            res.slot = index_t'(idx);
          end else if (stored < STORE_DEPTH) begin
            store_x[stored] = r.coord_x;
            store_y[stored] = r.coord_y;
            store_z[stored] = r.coord_z;
            res.slot = index_t'(stored);
            res.status = ST_ADDED;
            stored++;
          end else begin
            res.status = ST_FULL;
          end
        end
        ACT_FURTHEST: begin
          if (stored == 0) begin
            res.status = ST_EMPTY;
          end else begin
            best = 0;
            best_dot = dot(0, r);
            // Only a strictly larger sum wins, so ties keep the lower index.
            for (int unsigned i = 1; i < stored; i++) begin
              cur = dot(i, r);
              if (cur > best_dot) begin
                best_dot = cur;
                best = i;
              end
            end
            res.slot = index_t'(best);
            res.result_x = store_x[best];
            res.result_y = store_y[best];
            res.result_z = store_z[best];
          end
        end
        default: begin
          stored = 0;
        end
      endcase
      return res;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(predict(r));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: result with none outstanding, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot", want.slot, got.slot);
      compare_field("result_x", want.result_x, got.result_x);
      compare_field("result_y", want.result_y, got.result_y);
      compare_field("result_z", want.result_z, got.result_z);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

  endclass

endpackage

@@ bench/tb_point_store_support_search_top.sv @@
// ----------------------------------------------------------------------------
// Point store support search: testbench top
// Drives find, find-or-add, furthest and clear transactions with random
// gaps and stalls, and checks every result against the scoreboard's own
// copy of the store.
// ----------------------------------------------------------------------------
module tb_point_store_support_search_top;

  import psss_pkg::*;
  import psss_tb_pkg::*;

  localparam int RANDOM_ITEMS = 560;
  // The receiver's one long hold-off, long enough to back the block up.
  localparam int HOLD_CYCLES  = 400;
  // A full-store scan stays well within this watchdog limit.
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 20;

  localparam coord_t C_MAX  = 32'h7FFF_FFFF;
  localparam coord_t C_MIN  = 32'h8000_0000;
  localparam coord_t C_NEG1 = 32'hFFFF_FFFF;
  localparam coord_t C_ONE  = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  point_store_scoreboard sb = new();

  // Gap controls shared with the driving processes. Each side draws a gap
  // per transaction only while its flag is set.
  bit          send_gaps_on = 1'b1;
  bit          take_gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;
  // Points sent by find-or-add since the last clear, used to aim finds.
  point_t      added_pts [$];

  point_store_support_search_top #(
    .STORE_SIZE(STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor and watchdog. Signals are read at the rising edge, before any
  // nonblocking update of that edge lands, so each handshake is seen once.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        sb.note_request(req);
      end
      if (rsp_valid && rsp_ready) begin
        sb.check_response(rsp);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side. Ready is lowered only for a drawn gap or a hold-off, so it
  // never gets two updates in one time step. A hold-off request from the main
  // sequence is served after the next result transaction.
  initial begin
    int unsigned wait_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_n = take_gaps_on ? $urandom_range(0, 19) : 0;
      if (wait_n != 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high afterward, so back-to-back requests keep it up throughout.
  task automatic send_item(action_t act, coord_t x, coord_t y, coord_t z);
    int unsigned gap;
    req_t        r;
    gap = send_gaps_on ? $urandom_range(0, 19) : 0;
    r.action  = act;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every outstanding result has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Mixes full-range values with small integers, small raw fractions and
  // the extremes, so that exact matches and dot-product ties show up.
  function automatic coord_t pick_coord();
    int v;
    v = $urandom_range(0, 8);
    v = v - 4;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5:       return coord_t'(v * 65536);
      6:          return coord_t'(v);
      7: begin
        case ($urandom_range(0, 3))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return C_NEG1;
          default: return '0;
        endcase
      end
      default:    return coord_t'($urandom & 32'hFFFF_0000);
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.x = pick_coord();
    p.y = pick_coord();
    p.z = pick_coord();
    return p;
  endfunction

  // A stored point with one bit flipped in one coordinate: a near miss.
  function automatic point_t near_miss(point_t p);
    int unsigned b;
    b = $urandom_range(0, 31);
    case ($urandom_range(0, 2))
      0:       p.x[b] = ~p.x[b];
      1:       p.y[b] = ~p.y[b];
      default: p.z[b] = ~p.z[b];
    endcase
    return p;
  endfunction

  // One random transaction. The store is kept small by clearing it once it
  // reaches a few dozen points, so that scans stay short.
  task automatic random_item();
    point_t      p;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    p = random_point();
    if (added_pts.size() >= 40 || sel < 4) begin
      send_item(ACT_CLEAR, p.x, p.y, p.z);
      added_pts.delete();
    end else if (sel < 44) begin
      if (added_pts.size() != 0 && sel < 20) begin
        p = added_pts[$urandom_range(0, added_pts.size() - 1)];
      end else begin
        added_pts.push_back(p);
      end
      send_item(ACT_FIND_OR_ADD, p.x, p.y, p.z);
    end else if (sel < 72) begin
      if (added_pts.size() != 0 && sel < 62) begin
        p = added_pts[$urandom_range(0, added_pts.size() - 1)];
        if (sel >= 56) begin
          p = near_miss(p);
        end
      end
      send_item(ACT_FIND, p.x, p.y, p.z);
    end else begin
      send_item(ACT_FURTHEST, p.x, p.y, p.z);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The store starts empty: furthest reports empty and a
    // find reports not found; clearing an empty store is harmless.
    send_item(ACT_FURTHEST, 32'sd1, 32'sd2, 32'sd3);
    send_item(ACT_FIND, '0, '0, '0);
    send_item(ACT_CLEAR, C_NEG1, C_NEG1, C_NEG1);
    // Extreme coordinates are added, then found again by both lookups.
    send_item(ACT_FIND_OR_ADD, C_MAX, C_MIN, '0);
    send_item(ACT_FIND_OR_ADD, C_MIN, C_MAX, C_NEG1);
    send_item(ACT_FIND_OR_ADD, C_MAX, C_MIN, '0);
    send_item(ACT_FIND, C_MIN, C_MAX, C_NEG1);
    // Partial matches must not count as a match.
    send_item(ACT_FIND, C_MAX, C_MIN, 32'sd1);
    send_item(ACT_FIND, C_MAX, C_MAX, '0);
    send_item(ACT_FIND_OR_ADD, C_MIN, C_MIN, C_MIN);
    send_item(ACT_FIND_OR_ADD, C_ONE, '0, '0);
    send_item(ACT_FIND_OR_ADD, '0, C_ONE, '0);
    // The most negative direction against the most negative point gives a
    // sum of three times 2^62, which only fits in the full 65-bit width.
    send_item(ACT_FURTHEST, C_MIN, C_MIN, C_MIN);
    send_item(ACT_FURTHEST, C_MAX, C_MAX, C_MAX);
    // A zero direction ties every point, so index zero wins.
    send_item(ACT_FURTHEST, '0, '0, '0);
    // Points three and four tie along this direction; the lower one wins.
    send_item(ACT_FURTHEST, 32'sd1, 32'sd1, '0);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_FIND, C_MIN, C_MIN, C_MIN);
    send_item(ACT_FURTHEST, C_MAX, '0, '0);
    send_item(ACT_FIND_OR_ADD, 32'sd5, 32'sd6, 32'sd7);
    drain_results();
    send_item(ACT_CLEAR, '0, '0, '0);
    added_pts.delete();

    // Random part. Gap settings change every hundred transactions, which
    // also gives stretches without any idling on one or both sides.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        send_gaps_on = ($urandom_range(0, 3) != 0);
        take_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (n == 150 || n == 450) begin
        drain_results();
      end
      // The receiver holds off while the sender keeps offering without
      // gaps, so the block fills and has to stall its request side.
      if (n == 300) begin
        drain_results();
        hold_off_req = 1'b1;
        send_gaps_on = 1'b0;
      end
      if (n == 320) begin
        send_gaps_on = 1'b1;
      end
      random_item();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/psss_pkg.sv
rtl/core/psss_point_mem.sv
rtl/core/psss_dot_pipe.sv
rtl/core/point_store_support_search_top.sv
bench/psss_tb_pkg.sv
bench/tb_point_store_support_search_top.sv
